### design/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types, register indexes and reset values for the vertex transform.
// ----------------------------------------------------------------------------
package vmt_pkg;

  // Default arithmetic format: signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Port field widths, fixed by the interface
  localparam int COMP_W    = 32;
  localparam int NUM_COMP  = 4;
  localparam int CFG_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  // Partial sums: wide enough for four shifted products at any data width
  localparam int ACC_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_RIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_LEFT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_RIGHT = 3'd7;

  // Configuration write, fanned out to every cell
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } vmt_cfg_wr_t;

  // Vertex request as it travels down the cell chain
  typedef struct packed {
    logic                             last;
    logic [NUM_COMP-1:0][COMP_W-1:0]  comp;
    logic [NUM_COMP-1:0][ACC_W-1:0]   sum;
  } vmt_data_t;

  // Reset value of each register: identity matrix in Q16.16
  function automatic logic [CFG_W-1:0] reg_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    val = '0;
    case (idx)
      REG_ROW0_LEFT:  val = 64'h0000_0000_0001_0000;
      REG_ROW0_RIGHT: val = 64'h0;
      REG_ROW1_LEFT:  val = 64'h0001_0000_0000_0000;
      REG_ROW1_RIGHT: val = 64'h0;
      REG_ROW2_LEFT:  val = 64'h0;
      REG_ROW2_RIGHT: val = 64'h0000_0000_0001_0000;
      REG_ROW3_LEFT:  val = 64'h0;
      REG_ROW3_RIGHT: val = 64'h0001_0000_0000_0000;
      default:        val = '0;
    endcase
    return val;
  endfunction

endpackage

### design/vmt_cell.sv
// ----------------------------------------------------------------------------
// vmt_cell
// One matrix row: multiplies its vertex component by the row's four entries
// and adds the floored products to the partial sums from the previous cell.
// ----------------------------------------------------------------------------
module vmt_cell
  import vmt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  vmt_cfg_wr_t cfg,
  input  logic        vld_i,
  input  vmt_data_t   dat_i,
  output logic        vld_o,
  output vmt_data_t   dat_o
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam logic [CFG_IDX_W-1:0] IDX_LEFT  = CFG_IDX_W'(2 * CELL_IDX);
  localparam logic [CFG_IDX_W-1:0] IDX_RIGHT = CFG_IDX_W'(2 * CELL_IDX + 1);

  logic [CFG_W-1:0]           left_r;
  logic [CFG_W-1:0]           right_r;
  logic signed [DATA_WIDTH-1:0] ent [NUM_COMP];
  logic signed [DATA_WIDTH-1:0] cmp;
  logic signed [PROD_W-1:0]   prod_nxt [NUM_COMP];
  logic signed [PROD_W-1:0]   prod_r   [NUM_COMP];
  logic signed [PROD_W-1:0]   shft     [NUM_COMP];
  logic                       a_vld_r;
  vmt_data_t                  a_dat_r;
  logic                       b_vld_r;
  vmt_data_t                  b_dat_r;
  vmt_data_t                  b_dat_nxt;

  // Hold this cell's matrix row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= reg_reset(IDX_LEFT);
      right_r <= reg_reset(IDX_RIGHT);
    end else if (cfg.en) begin
      if (cfg.idx == IDX_LEFT) left_r <= cfg.data;
      if (cfg.idx == IDX_RIGHT) right_r <= cfg.data;
    end
  end

  // Take the low data-width bits of each entry and of the component
  always_comb begin
    ent[0] = left_r[DATA_WIDTH-1:0];
    ent[1] = left_r[32 +: DATA_WIDTH];
    ent[2] = right_r[DATA_WIDTH-1:0];
    ent[3] = right_r[32 +: DATA_WIDTH];
    cmp    = dat_i.comp[CELL_IDX][DATA_WIDTH-1:0];
    for (int j = 0; j < NUM_COMP; j++) begin
      prod_nxt[j] = cmp * ent[j];
    end
  end

  // Multiply stage: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= vld_i;
    end
  end

  // Multiply stage: payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_dat_r <= dat_i;
      for (int j = 0; j < NUM_COMP; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
    end
  end

  // Floor the products and accumulate
  always_comb begin
    b_dat_nxt = a_dat_r;
    for (int j = 0; j < NUM_COMP; j++) begin
      shft[j] = prod_r[j] >>> FRAC_BITS;
      b_dat_nxt.sum[j] = ACC_W'($signed(a_dat_r.sum[j]) + $signed(ACC_W'(shft[j])));
    end
  end

  // Accumulate stage: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  // Accumulate stage: payload
  always_ff @(posedge clk) begin
    if (adv) begin
      b_dat_r <= b_dat_nxt;
    end
  end

  assign vld_o = b_vld_r;
  assign dat_o = b_dat_r;

endmodule

### design/vertex_matrix_transform_unit.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform_unit
// Homogeneous 4x4 vertex transform (row-vector convention), signed fixed
// point, saturating, one vertex per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Accepts one vertex per clock while the output is not stalled and returns one
// transformed vertex per vertex, in order. The datapath is a chain of four row
// cells, one per input component, each with a multiply stage and an
// accumulate stage, followed by a saturating output register; a stall at the
// output freezes the whole chain and drops in_ready.
// The matrix sits in eight 64-bit registers (two entries each, low half
// first) and resets to identity; write it only while no vertex is in flight.
module vertex_matrix_transform_unit
  import vmt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COMP_W-1:0] in_x,
  input  logic signed [COMP_W-1:0] in_y,
  input  logic signed [COMP_W-1:0] in_z,
  input  logic signed [COMP_W-1:0] in_w,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COMP_W-1:0] out_x,
  output logic signed [COMP_W-1:0] out_y,
  output logic signed [COMP_W-1:0] out_z,
  output logic signed [COMP_W-1:0] out_w,
  output logic                     out_last,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic                         adv;
  vmt_cfg_wr_t                  cfg;
  logic                         vld_c [NUM_COMP+1];
  vmt_data_t                    dat_c [NUM_COMP+1];
  logic signed [ACC_W-1:0]      sum_s [NUM_COMP];
  logic signed [DATA_WIDTH-1:0] sat_v [NUM_COMP];
  logic [COMP_W-1:0]            res_nxt [NUM_COMP];
  logic [COMP_W-1:0]            res_r   [NUM_COMP];
  logic                         last_r;
  logic                         out_vld_r;

  // Advance the chain unless a finished result is held at the output
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  assign cfg.en   = cfg_wr_en;
  assign cfg.idx  = cfg_index;
  assign cfg.data = cfg_data;

  // Feed the head of the chain with zero partial sums
  assign vld_c[0]        = in_valid;
  assign dat_c[0].last   = in_last;
  assign dat_c[0].comp   = {in_w, in_z, in_y, in_x};
  assign dat_c[0].sum    = '0;

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_cell
    vmt_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .CELL_IDX   (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cfg   (cfg),
      .vld_i (vld_c[k]),
      .dat_i (dat_c[k]),
      .vld_o (vld_c[k+1]),
      .dat_o (dat_c[k+1])
    );
  end

  // Saturate each sum to the data width and sign-extend to the port
  always_comb begin
    for (int j = 0; j < NUM_COMP; j++) begin
      sum_s[j] = dat_c[NUM_COMP].sum[j];
      if (sum_s[j] > SAT_HI) begin
        sat_v[j] = SAT_HI[DATA_WIDTH-1:0];
      end else if (sum_s[j] < SAT_LO) begin
        sat_v[j] = SAT_LO[DATA_WIDTH-1:0];
      end else begin
        sat_v[j] = sum_s[j][DATA_WIDTH-1:0];
      end
      res_nxt[j] = COMP_W'(sat_v[j]);
    end
  end

  // Output register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_c[NUM_COMP];
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= dat_c[NUM_COMP].last;
      for (int j = 0; j < NUM_COMP; j++) begin
        res_r[j] <= res_nxt[j];
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_w     = res_r[3];
  assign out_last  = last_r;

endmodule

### design/vmt_checker.sv
// ----------------------------------------------------------------------------
// vmt_checker
// Port-level checks for the vertex transform unit, bound to the top level.
// ----------------------------------------------------------------------------
module vmt_checker
  import vmt_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [COMP_W-1:0] out_x,
  input logic signed [COMP_W-1:0] out_w,
  input logic                     out_last
);

  // Ready follows the output register only: free or draining
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_w)
      && $stable(out_last))
    else $error("stalled result changed");

  // Drop results at reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Never refuse an input while the output is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind vertex_matrix_transform_unit vmt_checker u_vmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_w     (out_w),
  .out_last  (out_last)
);

### tb/sv/vmt_transform_checker.sv
// ----------------------------------------------------------------------------
// vmt_transform_checker
// Watches the vertex, result and register ports of the vertex transform,
// keeps a mirror of the matrix, predicts each transformed vertex and
// compares every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module vmt_transform_checker
  import vmt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [COMP_W-1:0]    in_x,
  input  logic [COMP_W-1:0]    in_y,
  input  logic [COMP_W-1:0]    in_z,
  input  logic [COMP_W-1:0]    in_w,
  input  logic                 in_last,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COMP_W-1:0]    out_x,
  input  logic [COMP_W-1:0]    out_y,
  input  logic [COMP_W-1:0]    out_z,
  input  logic [COMP_W-1:0]    out_w,
  input  logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   error_count,
  output int                   pending_count,
  output int                   checked_count,
  output int                   batch_count
);

  localparam logic [COMP_W-1:0] UNIT_Q16   = 32'h0001_0000;
  localparam int                PRINT_CAP  = 40;

  typedef struct packed {
    logic [COMP_W-1:0] x;
    logic [COMP_W-1:0] y;
    logic [COMP_W-1:0] z;
    logic [COMP_W-1:0] w;
    logic              last;
  } vertex_t;

  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  vertex_t          vertex_expect_q [$];

  // Keep the low DATA_WIDTH bits, read as two's complement
  function automatic logic signed [63:0] narrow(input logic [COMP_W-1:0] v);
    logic signed [63:0] t;
    t = {32'b0, v};
    return (t <<< (64 - DATA_WIDTH)) >>> (64 - DATA_WIDTH);
  endfunction

  // Row vector times matrix: floor-shift each product, sum, saturate
  function automatic vertex_t transform_vertex(input vertex_t v);
    logic signed [63:0] comp [4];
    logic signed [63:0] acc;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic [CFG_W-1:0]   word;
    logic [COMP_W-1:0]  c;
    logic [COMP_W-1:0]  res [4];
    int                 entry;
    vertex_t            r;
    comp[0] = narrow(v.x);
    comp[1] = narrow(v.y);
    comp[2] = narrow(v.z);
    comp[3] = narrow(v.w);
    hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        entry = k * 4 + j;
        word  = matrix_regs[entry >> 1];
        c     = entry[0] ? word[63:32] : word[31:0];
        acc   = acc + ((comp[k] * narrow(c)) >>> FRAC_BITS);
      end
      if (acc > hi) begin
        acc = hi;
      end else if (acc < lo) begin
        acc = lo;
      end
      res[j] = acc[COMP_W-1:0];
    end
    r.x    = res[0];
    r.y    = res[1];
    r.z    = res[2];
    r.w    = res[3];
    r.last = v.last;
    return r;
  endfunction

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(input string field, input logic [COMP_W-1:0] got,
                                 input logic [COMP_W-1:0] want);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] result %0d: %s got %h, want %h", $time, checked_count, field,
               got, want);
    end
    error_count++;
  endtask

  // Mirror registers, queue predictions, compare results
  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    vertex_t req;
    if (!rst_n) begin
      matrix_regs[REG_ROW0_LEFT]  = {32'h0, UNIT_Q16};
      matrix_regs[REG_ROW0_RIGHT] = '0;
      matrix_regs[REG_ROW1_LEFT]  = {UNIT_Q16, 32'h0};
      matrix_regs[REG_ROW1_RIGHT] = '0;
      matrix_regs[REG_ROW2_LEFT]  = '0;
      matrix_regs[REG_ROW2_RIGHT] = {32'h0, UNIT_Q16};
      matrix_regs[REG_ROW3_LEFT]  = '0;
      matrix_regs[REG_ROW3_RIGHT] = {UNIT_Q16, 32'h0};
      vertex_expect_q.delete();
    end else begin
      if (cfg_wr_en) begin
        matrix_regs[cfg_index] = cfg_data;
      end
      // Compare an accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_x, out_y, out_z, out_w, out_last};
        checked_count++;
        if (got.last) begin
          batch_count++;
        end
        if (vertex_expect_q.size() == 0) begin
          report_mismatch("result with no vertex pending, x", got.x, 'x);
        end else begin
          want = vertex_expect_q.pop_front();
          if (got.x !== want.x) report_mismatch("x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("z", got.z, want.z);
          if (got.w !== want.w) report_mismatch("w", got.w, want.w);
          if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        end
      end
      // Predict an accepted request
      if (in_valid && in_ready) begin
        req = '{in_x, in_y, in_z, in_w, in_last};
        vertex_expect_q.push_back(transform_vertex(req));
      end
    end
    pending_count = vertex_expect_q.size();
  end

endmodule

### tb/sv/vertex_matrix_transform_unit_tb.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform_unit_tb
// Drives vertices through the 4x4 transform under several matrices (identity,
// all-max, all-min, random mixes), with random stalls on both channels, and
// leaves prediction and comparison to the attached checker.
// ----------------------------------------------------------------------------
module vertex_matrix_transform_unit_tb;
  import vmt_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES      = 6;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 12;

  localparam logic [COMP_W-1:0] MAX_Q   = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] MIN_Q   = 32'h8000_0000;
  localparam logic [COMP_W-1:0] NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [COMP_W-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [COMP_W-1:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [COMP_W-1:0] HALF_Q  = 32'h0000_8000;
  localparam logic [COMP_W-1:0] NEG_HALF = 32'hFFFF_8000;

  typedef enum int {MIX_SMALL, MIX_FULL, MIX_ANY, MIX_SPARSE} coef_mix_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic signed [COMP_W-1:0] in_x      = '0;
  logic signed [COMP_W-1:0] in_y      = '0;
  logic signed [COMP_W-1:0] in_z      = '0;
  logic signed [COMP_W-1:0] in_w      = '0;
  logic                     in_last   = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [COMP_W-1:0] out_x;
  logic signed [COMP_W-1:0] out_y;
  logic signed [COMP_W-1:0] out_z;
  logic signed [COMP_W-1:0] out_w;
  logic                     out_last;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data  = '0;

  int                error_count;
  int                pending_count;
  int                checked_count;
  int                batch_count;
  int                sent_count    = 0;
  int                write_count   = 0;
  int                setting_count = 0;
  int                idle_cycles   = 0;
  bit                calm          = 1'b0;
  logic [COMP_W-1:0] coef_set [16];

  vertex_matrix_transform_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_w      (in_w),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .out_last  (out_last),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vmt_transform_checker #(
    .DATA_WIDTH (DATA_WIDTH_DEF),
    .FRAC_BITS  (FRAC_BITS_DEF)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_z          (in_z),
    .in_w          (in_w),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .batch_count   (batch_count)
  );

  always #5 clk = ~clk;

  // Stall the result channel in random bursts, except in the calm phase
  always begin
    @(negedge clk);
    if (!rst_n || calm || $urandom_range(0, 99) >= 15) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("vertex_matrix_transform_unit_tb: done, errors");
      $finish;
    end
  end

  // Present one request and hold it until accepted; valid stays high
  task automatic send_vertex(input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
                             input logic [COMP_W-1:0] z, input logic [COMP_W-1:0] w,
                             input logic last);
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_w     <= w;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_count++;
  endtask

  // Drop valid for a random burst with the given chance
  task automatic sender_gap(input int gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Hold off until every predicted result has come back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Load all eight registers from coef_set, low entry in the low half
  task automatic write_matrix();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= {coef_set[2 * r + 1], coef_set[2 * r]};
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    write_count += NUM_REGS;
    setting_count++;
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    logic [COMP_W-1:0] r;
    int                pick;
    r    = $urandom();
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: rand_comp = r;
      4, 5, 6:    rand_comp = {{13{r[18]}}, r[18:0]};  // within +-4.0
      7, 8:       rand_comp = {{5{r[26]}}, r[26:0]};   // within +-1024.0
      default: begin
        case (r[1:0])
          2'd0:    rand_comp = MAX_Q;
          2'd1:    rand_comp = MIN_Q;
          2'd2:    rand_comp = '0;
          default: rand_comp = NEG_LSB;
        endcase
      end
    endcase
  endfunction

  function automatic logic [COMP_W-1:0] rand_coef(input coef_mix_t mix);
    logic [COMP_W-1:0] r;
    r = $urandom();
    case (mix)
      MIX_SMALL: rand_coef = {{14{r[17]}}, r[17:0]};  // within +-2.0
      MIX_FULL:  rand_coef = r;
      MIX_ANY:   rand_coef = rand_comp();
      default: begin
        // half zero, the rest unit or extreme
        case (r[4:2])
          3'd0:    rand_coef = MAX_Q;
          3'd1:    rand_coef = MIN_Q;
          3'd2:    rand_coef = ONE_Q;
          3'd3:    rand_coef = NEG_ONE;
          default: rand_coef = '0;
        endcase
      end
    endcase
  endfunction

  initial begin
    coef_mix_t mix;
    int        gap_pct;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    setting_count = 1;

    // Identity after reset: zero, extremes, smallest negative, fractions
    send_vertex('0, '0, '0, '0, 1'b0);
    send_vertex(MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b1);
    send_vertex(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b0);
    send_vertex(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, 1'b1);
    send_vertex(ONE_Q, NEG_ONE, HALF_Q, NEG_HALF, 1'b0);

    // All-max matrix: saturate both ways, floor rounding of negative products
    drain();
    foreach (coef_set[i]) coef_set[i] = MAX_Q;
    write_matrix();
    send_vertex(MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0);
    send_vertex(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b1);
    send_vertex(32'h1, 32'h1, 32'h1, 32'h1, 1'b0);
    send_vertex(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, 1'b1);

    // All-min matrix: min times min overflows high
    drain();
    foreach (coef_set[i]) coef_set[i] = MIN_Q;
    write_matrix();
    send_vertex(MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0);
    send_vertex(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1'b0);
    send_vertex(NEG_LSB, ONE_Q, NEG_ONE, HALF_Q, 1'b1);

    // Random phases, each under a fresh matrix; the last runs with no idling
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      calm    = (phase == NUM_PHASES - 1);
      gap_pct = calm ? 0 : (phase % 3) * 20;
      mix     = coef_mix_t'(phase % 4);
      foreach (coef_set[i]) coef_set[i] = rand_coef(mix);
      write_matrix();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sender_gap(gap_pct);
        send_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                    $urandom_range(0, 7) == 0);
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d vertices in %0d batches under %0d matrix settings (%0d reg writes)",
             sent_count, batch_count, setting_count, write_count);
    $display("%0d results compared, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("vertex_matrix_transform_unit_tb: done, clean");
    end else begin
      $display("vertex_matrix_transform_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
design/vmt_pkg.sv
design/vmt_cell.sv
design/vertex_matrix_transform_unit.sv
design/vmt_checker.sv
tb/sv/vmt_transform_checker.sv
tb/sv/vertex_matrix_transform_unit_tb.sv
